>>> rtl/sgrc_pkg.sv
// Shared types, codes and the intra-cell join table of the slash grid region counter.
`timescale 1ns / 1ps
`default_nettype none

package sgrc_pkg;

  localparam int unsigned CFG_W = 6;
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 13;

  localparam logic [IN_W-1:0]  CH_SLASH  = 8'd47;
  localparam logic [IN_W-1:0]  CH_BACK   = 8'd92;
  localparam logic [OUT_W-1:0] COUNT_MAX = 13'd8191;

  // triangle codes inside one cell
  localparam logic [1:0] TRI_TOP    = 2'd0;
  localparam logic [1:0] TRI_RIGHT  = 2'd1;
  localparam logic [1:0] TRI_BOTTOM = 2'd2;
  localparam logic [1:0] TRI_LEFT   = 2'd3;

  // join step codes for one cell
  localparam int unsigned JOIN_W = 3;
  localparam logic [JOIN_W-1:0] J_UP   = 3'd3;
  localparam logic [JOIN_W-1:0] J_LEFT = 3'd4;

  typedef enum logic [1:0] {
    KIND_SLASH,
    KIND_BACK,
    KIND_BLANK
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_JOIN,
    ST_WALK,
    ST_COMP,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       vld;
    logic [1:0] oa;
    logic [1:0] ob;
  } join_t;

  function automatic kind_e char_kind(input logic [IN_W-1:0] ch);
    kind_e k;
    if (ch == CH_SLASH) begin
      k = KIND_SLASH;
    end else if (ch == CH_BACK) begin
      k = KIND_BACK;
    end else begin
      k = KIND_BLANK;
    end
    return k;
  endfunction

  // intra-cell joins, steps 0..2
  function automatic join_t join_lut(input kind_e k, input logic [JOIN_W-1:0] j);
    join_t r;
    r = '{vld: 1'b0, oa: TRI_TOP, ob: TRI_TOP};
    case (k)
      KIND_SLASH: begin
        if (j == 3'd0) r = '{vld: 1'b1, oa: TRI_TOP,   ob: TRI_LEFT};
        if (j == 3'd1) r = '{vld: 1'b1, oa: TRI_RIGHT, ob: TRI_BOTTOM};
      end
      KIND_BACK: begin
        if (j == 3'd0) r = '{vld: 1'b1, oa: TRI_TOP,    ob: TRI_RIGHT};
        if (j == 3'd1) r = '{vld: 1'b1, oa: TRI_BOTTOM, ob: TRI_LEFT};
      end
      default: begin
        if (j == 3'd0) r = '{vld: 1'b1, oa: TRI_TOP,    ob: TRI_RIGHT};
        if (j == 3'd1) r = '{vld: 1'b1, oa: TRI_RIGHT,  ob: TRI_BOTTOM};
        if (j == 3'd2) r = '{vld: 1'b1, oa: TRI_BOTTOM, ob: TRI_LEFT};
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slash_grid_region_counter.sv
// Top level of the slash grid region counter: union-find over a parent memory.
//
// Usage: write grid_side on the cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i),
// then stream the N*N cell characters in row-major order on s_axis, one item
// per cell ('/', backslash, anything else blank). After the last cell one item
// with the region count comes out on m_axis; all other cells give no result.
// A cell walks parent chains in one memory (one read port, one write
// port, registered read data). A new cell is taken only while the block is
// idle, so each cell waits until every join of the one before it is done.
// The grid's last cell adds a scan of its 4*N*N entries that counts roots
// and rewrites identity into the scanned entries; then the result register
// is loaded once it is free.
// Reset and every config write start a clearing pass that writes identity
// into the whole memory of 4*MAX_SIDE*MAX_SIDE entries (4096 by default);
// s_axis_tready stays low meanwhile. Config writes are always taken.
// The result sits in an output register: while the receiver stalls the next
// grid's cells are still taken; only the end of that next grid waits until
// the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none

module slash_grid_region_counter #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // config: grid_side
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [sgrc_pkg::CFG_W-1:0] cfg_data_i,
  // input items, tdata: [7:0] cell_char
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,
  // result items, tdata: [12:0] region_count, [15:13] zero
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata
);

  localparam int unsigned TRI    = 4 * MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W = $clog2(TRI);
  localparam int unsigned TRI_W  = $clog2(TRI + 1);
  localparam int unsigned RC_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW     = (TRI_W > sgrc_pkg::OUT_W) ? TRI_W : sgrc_pkg::OUT_W;

  sgrc_pkg::state_e state_q, state_d;
  sgrc_pkg::kind_e  kind_q, kind_d;

  logic [RC_W-1:0]            side_q, side_d, row_q, row_d, col_q, col_d;
  logic [TRI_W-1:0]           base_q, base_d, sc_q, sc_d, cnt_q;
  logic [sgrc_pkg::JOIN_W-1:0] j_q, j_d;
  logic [ADDR_W-1:0]          cur_q, cur_d, x_q, x_d, root_q, root_d;
  logic [ADDR_W-1:0]          ra_q, ra_d, bop_q, bop_d, si_q;
  logic                       half_q, half_d, sv_q, sv_d, cnt_clr;
  logic                       out_valid_q, out_valid_d;
  logic [sgrc_pkg::OUT_W-1:0] out_data_q, out_data_d;

  // parent memory
  logic [ADDR_W-1:0] mem [TRI];
  logic [ADDR_W-1:0] mem_ra, mem_wa, mem_wd, rdata_q;
  logic              mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // handshakes
  logic in_acc, cfg_acc, out_free;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i;
  assign s_axis_tready = (state_q == sgrc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - sgrc_pkg::OUT_W){1'b0}}, out_data_q};

  // current join pair
  sgrc_pkg::join_t jl;
  logic              j_vld, j_end, last_col, last_cell;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic [TRI_W-1:0]  side4;

  assign side4     = TRI_W'(side_q) << 2;
  assign last_col  = (col_q + RC_W'(1)) == side_q;
  assign last_cell = last_col && ((row_q + RC_W'(1)) == side_q);

  always_comb begin
    jl     = sgrc_pkg::join_lut(kind_q, j_q);
    j_end  = 1'b0;
    j_vld  = 1'b0;
    a_addr = ADDR_W'(base_q);
    b_addr = ADDR_W'(base_q);
    if (j_q < sgrc_pkg::J_UP) begin
      j_vld  = jl.vld;
      a_addr = ADDR_W'(base_q + TRI_W'(jl.oa));
      b_addr = ADDR_W'(base_q + TRI_W'(jl.ob));
    end else if (j_q == sgrc_pkg::J_UP) begin
      // top of this cell to bottom of the cell above
      j_vld  = (row_q != '0);
      a_addr = ADDR_W'(base_q + TRI_W'(sgrc_pkg::TRI_TOP));
      b_addr = ADDR_W'(base_q - side4 + TRI_W'(sgrc_pkg::TRI_BOTTOM));
    end else if (j_q == sgrc_pkg::J_LEFT) begin
      // left of this cell to right of the cell on the left
      j_vld  = (col_q != '0);
      a_addr = ADDR_W'(base_q + TRI_W'(sgrc_pkg::TRI_LEFT));
      b_addr = ADDR_W'(base_q - TRI_W'(3));
    end else begin
      j_end  = 1'b1;
    end
  end

  // saturated grid side from a config write
  logic [6:0] cfg_v7, cfg_sat;
  assign cfg_v7  = {1'b0, cfg_data_i};
  assign cfg_sat = (cfg_v7 == 7'd0) ? 7'd1 :
                   ((cfg_v7 > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : cfg_v7);

  // saturated count for the result
  logic [CW-1:0] cnt_ext;
  logic [sgrc_pkg::OUT_W-1:0] cnt_sat;
  assign cnt_ext = CW'(cnt_q);
  assign cnt_sat = (cnt_ext > CW'(sgrc_pkg::COUNT_MAX)) ? sgrc_pkg::COUNT_MAX
                                                        : cnt_ext[sgrc_pkg::OUT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgrc_pkg::ST_CLEAR: begin
        if (sc_q == TRI_W'(TRI - 1)) state_d = sgrc_pkg::ST_IDLE;
      end
      sgrc_pkg::ST_IDLE: begin
        if (in_acc) state_d = sgrc_pkg::ST_JOIN;
      end
      sgrc_pkg::ST_JOIN: begin
        if (j_end) begin
          state_d = last_cell ? sgrc_pkg::ST_SCAN : sgrc_pkg::ST_IDLE;
        end else if (j_vld) begin
          state_d = sgrc_pkg::ST_WALK;
        end
      end
      sgrc_pkg::ST_WALK: begin
        if (rdata_q == cur_q) state_d = sgrc_pkg::ST_COMP;
      end
      sgrc_pkg::ST_COMP: begin
        if (rdata_q == root_q) begin
          state_d = half_q ? sgrc_pkg::ST_JOIN : sgrc_pkg::ST_WALK;
        end
      end
      sgrc_pkg::ST_SCAN: begin
        if (sc_q == base_q - TRI_W'(1)) state_d = sgrc_pkg::ST_TAIL;
      end
      sgrc_pkg::ST_TAIL: state_d = sgrc_pkg::ST_DONE;
      sgrc_pkg::ST_DONE: begin
        if (out_free) state_d = sgrc_pkg::ST_IDLE;
      end
      default: state_d = sgrc_pkg::ST_CLEAR;
    endcase
    if (cfg_acc) state_d = sgrc_pkg::ST_CLEAR;
  end

  // datapath and memory controls
  always_comb begin
    side_d      = side_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    sc_d        = sc_q;
    j_d         = j_q;
    kind_d      = kind_q;
    cur_d       = cur_q;
    x_d         = x_q;
    root_d      = root_q;
    ra_d        = ra_q;
    bop_d       = bop_q;
    half_d      = half_q;
    sv_d        = 1'b0;
    cnt_clr     = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_ra      = cur_q;
    mem_we      = 1'b0;
    mem_wa      = x_q;
    mem_wd      = root_q;
    unique case (state_q)
      sgrc_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sc_q[ADDR_W-1:0];
        mem_wd = sc_q[ADDR_W-1:0];
        sc_d   = sc_q + TRI_W'(1);
      end
      sgrc_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_d = sgrc_pkg::char_kind(s_axis_tdata);
          j_d    = '0;
        end
      end
      sgrc_pkg::ST_JOIN: begin
        if (j_end) begin
          base_d = base_q + TRI_W'(4);
          col_d  = last_col ? '0 : col_q + RC_W'(1);
          row_d  = last_col ? row_q + RC_W'(1) : row_q;
          sc_d   = '0;
          cnt_clr = 1'b1;
        end else if (j_vld) begin
          cur_d  = a_addr;
          x_d    = a_addr;
          bop_d  = b_addr;
          half_d = 1'b0;
          mem_ra = a_addr;
        end else begin
          j_d = j_q + sgrc_pkg::JOIN_W'(1);
        end
      end
      sgrc_pkg::ST_WALK: begin
        if (rdata_q == cur_q) begin
          root_d = cur_q;
          mem_ra = x_q;
        end else begin
          cur_d  = rdata_q;
          mem_ra = rdata_q;
        end
      end
      sgrc_pkg::ST_COMP: begin
        if (rdata_q == root_q) begin
          if (!half_q) begin
            ra_d   = root_q;
            half_d = 1'b1;
            x_d    = bop_q;
            cur_d  = bop_q;
            mem_ra = bop_q;
          end else begin
            // link root of a under root of b
            mem_we = 1'b1;
            mem_wa = ra_q;
            mem_wd = root_q;
            j_d    = j_q + sgrc_pkg::JOIN_W'(1);
          end
        end else begin
          // path compression hop
          mem_we = 1'b1;
          mem_wa = x_q;
          mem_wd = root_q;
          x_d    = rdata_q;
          mem_ra = rdata_q;
        end
      end
      sgrc_pkg::ST_SCAN: begin
        // read old parent for the count, restore identity for the next grid
        mem_ra = sc_q[ADDR_W-1:0];
        mem_we = 1'b1;
        mem_wa = sc_q[ADDR_W-1:0];
        mem_wd = sc_q[ADDR_W-1:0];
        sv_d   = 1'b1;
        sc_d   = sc_q + TRI_W'(1);
      end
      sgrc_pkg::ST_TAIL: begin
      end
      sgrc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = cnt_sat;
          row_d       = '0;
          col_d       = '0;
          base_d      = '0;
        end
      end
      default: begin
      end
    endcase
    if (cfg_acc) begin
      side_d = RC_W'(cfg_sat);
      row_d  = '0;
      col_d  = '0;
      base_d = '0;
      sc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgrc_pkg::ST_CLEAR;
      side_q      <= RC_W'(1);
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      sc_q        <= '0;
      j_q         <= '0;
      half_q      <= 1'b0;
      sv_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      sc_q        <= sc_d;
      j_q         <= j_d;
      half_q      <= half_d;
      sv_q        <= sv_d;
      out_valid_q <= out_valid_d;
      if (cnt_clr) begin
        cnt_q <= '0;
      end else if (sv_q && (rdata_q == si_q)) begin
        cnt_q <= cnt_q + TRI_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    cur_q      <= cur_d;
    x_q        <= x_d;
    root_q     <= root_d;
    ra_q       <= ra_d;
    bop_q      <= bop_d;
    si_q       <= sc_q[ADDR_W-1:0];
    out_data_q <= out_data_d;
  end

  // assertions
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgrc_pkg::ST_IDLE) |-> !mem_we)
    else $error("parent memory written while idle");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (TRI_W'(mem_wa) < TRI_W'(TRI)))
    else $error("parent memory write beyond the store");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == sgrc_pkg::ST_DONE))
    else $error("result raised outside the end of a grid");

  a_count_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgrc_pkg::ST_DONE) |-> ((cnt_q != '0) && (cnt_q <= base_q)))
    else $error("region count out of range at grid end");

  a_walk_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgrc_pkg::ST_WALK) |-> !mem_we)
    else $error("parent memory written during a root walk");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the slash grid region counter: union-find predictor, directed and random grids.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_SIDE   = 32;
  localparam int unsigned TRI_CNT    = 4 * MAX_SIDE * MAX_SIDE;
  localparam int unsigned TAIL_CYC   = 256;      // covers the last cell of a cut-off grid
  localparam int unsigned RAND_CELLS = 450;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [sgrc_pkg::CFG_W-1:0] cfg_data_i    = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata  = '0;   // [7:0] cell_char
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b1;
  logic [15:0]                m_axis_tdata;         // [12:0] region_count, [15:13] zero

  // grid model: triangle parents, current side and position
  logic [11:0]                tri_parent [TRI_CNT];
  int unsigned                side_now;
  int unsigned                row_now;
  int unsigned                col_now;
  logic [sgrc_pkg::OUT_W-1:0] region_counts_due [$];
  logic [sgrc_pkg::OUT_W-1:0] count_want;

  int unsigned      cells_sent  = 0;
  int unsigned      err_cnt     = 0;
  int unsigned      rdy_wait    = 0;
  bit               no_gaps     = 1'b0;

  slash_grid_region_counter #(
    .MAX_SIDE(MAX_SIDE)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_grid();
    for (int i = 0; i < TRI_CNT; i++) tri_parent[i] = 12'(i);
    row_now = 0;
    col_now = 0;
  endfunction

  function automatic int unsigned side_of(input logic [sgrc_pkg::CFG_W-1:0] v);
    int unsigned s;
    s = v;
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // root lookup with path compression
  function automatic logic [11:0] root_of(input logic [11:0] x);
    logic [11:0] r;
    logic [11:0] nxt;
    r = x;
    while (tri_parent[r] != r) r = tri_parent[r];
    while (tri_parent[x] != r) begin
      nxt           = tri_parent[x];
      tri_parent[x] = r;
      x             = nxt;
    end
    return r;
  endfunction

  function automatic void link_tris(input int unsigned a, input int unsigned b);
    logic [11:0] ra;
    logic [11:0] rb;
    ra = root_of(12'(a));
    rb = root_of(12'(b));
    tri_parent[ra] = rb;
  endfunction

  // joins for one cell; the grid's last cell queues the region count
  function automatic void place_cell(input logic [7:0] ch);
    int unsigned base;
    int unsigned roots;
    base = 4 * (row_now * side_now + col_now);
    if (ch == sgrc_pkg::CH_SLASH) begin
      link_tris(base + sgrc_pkg::TRI_TOP, base + sgrc_pkg::TRI_LEFT);
      link_tris(base + sgrc_pkg::TRI_RIGHT, base + sgrc_pkg::TRI_BOTTOM);
    end else if (ch == sgrc_pkg::CH_BACK) begin
      link_tris(base + sgrc_pkg::TRI_TOP, base + sgrc_pkg::TRI_RIGHT);
      link_tris(base + sgrc_pkg::TRI_BOTTOM, base + sgrc_pkg::TRI_LEFT);
    end else begin
      link_tris(base + sgrc_pkg::TRI_TOP, base + sgrc_pkg::TRI_RIGHT);
      link_tris(base + sgrc_pkg::TRI_RIGHT, base + sgrc_pkg::TRI_BOTTOM);
      link_tris(base + sgrc_pkg::TRI_BOTTOM, base + sgrc_pkg::TRI_LEFT);
    end
    if (row_now > 0) begin
      link_tris(base + sgrc_pkg::TRI_TOP, base - 4 * side_now + sgrc_pkg::TRI_BOTTOM);
    end
    if (col_now > 0) link_tris(base + sgrc_pkg::TRI_LEFT, base - 4 + sgrc_pkg::TRI_RIGHT);
    col_now++;
    if (col_now >= side_now) begin
      col_now = 0;
      row_now++;
    end
    if (row_now >= side_now) begin
      roots = 0;
      for (int i = 0; i < 4 * side_now * side_now; i++) begin
        if (tri_parent[i] == 12'(i)) roots++;
      end
      if (roots > sgrc_pkg::COUNT_MAX) roots = sgrc_pkg::COUNT_MAX;
      region_counts_due.push_back(sgrc_pkg::OUT_W'(roots));
      clear_grid();
    end
  endfunction

  function automatic logic [7:0] rand_cell();
    case ($urandom_range(0, 9))
      0, 1, 2: return sgrc_pkg::CH_SLASH;
      3, 4, 5: return sgrc_pkg::CH_BACK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_cell(input logic [7:0] ch);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    place_cell(ch);
    cells_sent++;
  endtask

  task automatic send_grid();
    for (int k = 0; k < side_now * side_now; k++) send_cell(rand_cell());
  endtask

  // hold the input until every count is out and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (region_counts_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [sgrc_pkg::CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b1;
    cfg_data_i    <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    side_now = side_of(v);
    clear_grid();
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (region_counts_due.size() == 0) begin
        $display("%0t: region_count with none expected, got %0d", $time,
                 m_axis_tdata[sgrc_pkg::OUT_W-1:0]);
        err_cnt++;
      end else begin
        count_want = region_counts_due.pop_front();
        if (m_axis_tdata[sgrc_pkg::OUT_W-1:0] !== count_want) begin
          $display("%0t: region_count expected %0d, got %0d", $time, count_want,
                   m_axis_tdata[sgrc_pkg::OUT_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[15:sgrc_pkg::OUT_W] !== '0) begin
          $display("%0t: tdata pad expected 0, got %0h", $time,
                   m_axis_tdata[15:sgrc_pkg::OUT_W]);
          err_cnt++;
        end
      end
      rdy_wait = no_gaps ? 0 : $urandom_range(0, 3);
      if (rdy_wait != 0) m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      if (rdy_wait <= 1) m_axis_tready <= 1'b1;
      rdy_wait--;
    end
  end

  // side 1 after reset: each character alone
  task automatic test_one_cell_grids();
    send_cell(sgrc_pkg::CH_SLASH);
    send_cell(sgrc_pkg::CH_BACK);
    send_cell(8'h00);
    send_cell(8'hFF);
    send_cell(8'h20);
    settle();
  endtask

  // zero side is taken as one
  task automatic test_side_floor();
    cfg_write('0);
    send_cell(8'h41);
    settle();
  endtask

  task automatic test_two_by_two();
    cfg_write(sgrc_pkg::CFG_W'(2));
    send_cell(sgrc_pkg::CH_SLASH);
    send_cell(sgrc_pkg::CH_BACK);
    send_cell(sgrc_pkg::CH_BACK);
    send_cell(sgrc_pkg::CH_SLASH);
    settle();
  endtask

  // a write in the middle of a grid throws the partial grid away
  task automatic test_restart_mid_grid();
    cfg_write(sgrc_pkg::CFG_W'(3));
    repeat (4) send_cell(rand_cell());
    settle();
    cfg_write(sgrc_pkg::CFG_W'(MAX_SIDE));
    repeat (5) send_cell(rand_cell());
    settle();
    cfg_write(sgrc_pkg::CFG_W'(2));
    send_cell(sgrc_pkg::CH_BACK);
    send_cell(sgrc_pkg::CH_SLASH);
    send_cell(sgrc_pkg::CH_SLASH);
    send_cell(sgrc_pkg::CH_BACK);
    settle();
  endtask

  // all-ones write saturates to the largest grid; two rows and a few cells
  // run the joins to the row above at full width
  task automatic test_max_side();
    cfg_write('1);
    repeat (2 * MAX_SIDE + 5) send_cell(rand_cell());
    settle();
  endtask

  task automatic test_random_grids();
    int unsigned first_cells;
    int unsigned partial;
    first_cells = cells_sent;
    while (cells_sent - first_cells < RAND_CELLS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(sgrc_pkg::CFG_W'($urandom_range(10, 16)));
      end else begin
        cfg_write(sgrc_pkg::CFG_W'($urandom_range(0, 9)));
      end
      repeat ($urandom_range(1, 3)) send_grid();
      if ($urandom_range(0, 4) == 0) begin
        partial = $urandom_range(0, side_now * side_now - 1);
        repeat (partial) send_cell(rand_cell());
      end
      settle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    side_now = 1;
    clear_grid();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_one_cell_grids();
    test_side_floor();
    test_two_by_two();
    test_restart_mid_grid();
    test_max_side();
    test_random_grids();
    settle();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
